@@ hdl/text_screen_writer_dirty_span_assert.svh @@
// Assertion macros used by the checker file tsw_checker.sv.
`ifndef TEXT_SCREEN_WRITER_DIRTY_SPAN_ASSERT_SVH
`define TEXT_SCREEN_WRITER_DIRTY_SPAN_ASSERT_SVH

// Same-cycle implication, off while reset is asserted.
`define TSW_ASSERT_IMP(LBL, CLK, RSTN, ANT, CON) \
  LBL: assert property (@(posedge CLK) disable iff (!(RSTN)) (ANT) |-> (CON)) \
    else $error("tsw: same-cycle check failed");

// Next-cycle implication, off while reset is asserted.
`define TSW_ASSERT_NEXT(LBL, CLK, RSTN, ANT, CON) \
  LBL: assert property (@(posedge CLK) disable iff (!(RSTN)) (ANT) |=> (CON)) \
    else $error("tsw: next-cycle check failed");

// Next-cycle implication that also runs through reset.
`define TSW_ASSERT_NEXT_ALWAYS(LBL, CLK, ANT, CON) \
  LBL: assert property (@(posedge CLK) (ANT) |=> (CON)) \
    else $error("tsw: reset check failed");

`endif

@@ hdl/tsw_pkg.sv @@
package tsw_pkg;

  localparam int TSW_MAX_COLS    = 128;
  localparam int TSW_MAX_ROWS    = 64;
  localparam int TSW_COL_W       = 7;
  localparam int TSW_ROW_W       = 6;
  localparam int TSW_ADDR_W      = TSW_ROW_W + TSW_COL_W;
  localparam int TSW_CELLS       = TSW_MAX_COLS * TSW_MAX_ROWS;
  localparam int TSW_CHAR_W      = 16;
  localparam int TSW_ATTR_W      = 8;
  localparam int TSW_CELL_W      = TSW_CHAR_W + TSW_ATTR_W;
  localparam int TSW_CODE_W      = 21;
  localparam int TSW_POS_W       = 8;
  localparam int TSW_REQ_W       = 3;
  localparam int TSW_SCOLS_W     = 8;
  localparam int TSW_SROWS_W     = 7;
  localparam int TSW_TAB_WIDTH   = 8;
  localparam int TSW_QUEUE_DEPTH = 2;

  localparam int TSW_CFG_IDX_W  = 2;
  localparam int TSW_CFG_DATA_W = 8;

  // Register indexes on the configuration port
  localparam logic [TSW_CFG_IDX_W-1:0] CFG_SCREEN_COLS = 2'd0;
  localparam logic [TSW_CFG_IDX_W-1:0] CFG_SCREEN_ROWS = 2'd1;
  localparam logic [TSW_CFG_IDX_W-1:0] CFG_CURSOR_EN   = 2'd2;

  // Request types
  localparam logic [TSW_REQ_W-1:0] REQ_WRITE = 3'd0;
  localparam logic [TSW_REQ_W-1:0] REQ_GOTO  = 3'd1;
  localparam logic [TSW_REQ_W-1:0] REQ_FLUSH = 3'd2;
  localparam logic [TSW_REQ_W-1:0] REQ_CLEAR = 3'd3;
  localparam logic [TSW_REQ_W-1:0] REQ_READ  = 3'd4;

  // Special character codes
  localparam logic [TSW_CODE_W-1:0] CODE_NUL = 21'h00000;
  localparam logic [TSW_CODE_W-1:0] CODE_TAB = 21'h00009;
  localparam logic [TSW_CODE_W-1:0] CODE_LF  = 21'h0000A;
  localparam logic [TSW_CODE_W-1:0] CODE_CR  = 21'h0000D;
  localparam logic [TSW_CODE_W-1:0] CODE_BMP_MAX = 21'h0FFFF;

  localparam logic [TSW_CHAR_W-1:0] CHAR_SPACE = 16'h0020;
  localparam logic [TSW_CHAR_W-1:0] CHAR_REPL  = 16'h00BF;
  localparam logic [TSW_ATTR_W-1:0] ATTR_BLANK = 8'h00;

  // Back-end operations
  localparam int TSW_OP_W = 3;
  localparam logic [TSW_OP_W-1:0] OP_PUT   = 3'd0;
  localparam logic [TSW_OP_W-1:0] OP_TAB   = 3'd1;
  localparam logic [TSW_OP_W-1:0] OP_NL    = 3'd2;
  localparam logic [TSW_OP_W-1:0] OP_GOTO  = 3'd3;
  localparam logic [TSW_OP_W-1:0] OP_FLUSH = 3'd4;
  localparam logic [TSW_OP_W-1:0] OP_CLEAR = 3'd5;
  localparam logic [TSW_OP_W-1:0] OP_READ  = 3'd6;

  typedef struct packed {
    logic [TSW_OP_W-1:0]   op;
    logic [TSW_CHAR_W-1:0] ch;
    logic [TSW_ATTR_W-1:0] attr;
    logic [TSW_POS_W-1:0]  col_pos;
    logic [TSW_POS_W-1:0]  row_pos;
  } tsw_cmd_t;

  typedef struct packed {
    logic [TSW_SCOLS_W-1:0] screen_cols;
    logic [TSW_SROWS_W-1:0] screen_rows;
    logic                   cursor_en;
  } tsw_cfg_t;

  typedef struct packed {
    logic                  span_valid;
    logic [TSW_ROW_W-1:0]  span_first_row;
    logic [TSW_ROW_W-1:0]  span_last_row;
    logic [TSW_COL_W-1:0]  span_first_col;
    logic [TSW_COL_W-1:0]  span_last_col;
    logic                  cursor_valid;
    logic [TSW_COL_W-1:0]  cursor_col;
    logic [TSW_ROW_W-1:0]  cursor_row;
    logic                  read_valid;
    logic [TSW_CHAR_W-1:0] read_char;
    logic [TSW_ATTR_W-1:0] read_attr;
  } tsw_res_t;

endpackage

@@ hdl/text_screen_writer_dirty_span.sv @@
// Channel   Handshake            Beat contents
// in_       in_valid / in_stall  req_type, char_code, attribute, col_pos, row_pos
// out_      out_valid/ out_stall span, cursor and read-cell fields (zero if unused)
// cfg_      cfg_valid/ cfg_ready register index, write data (always ready)
//
// A plain character reads the single cell RAM, then compares and writes
// back the cell. Tab does the same for TAB_WIDTH cells in turn.
// Goto, newline and flush act as they leave the queue; read cell reads
// the RAM, then reports it. Clear sweeps all 8192 cells, one per cycle,
// then reports the screen. After reset the same sweep blanks the RAM
// with in_stall high. A stalled result does not block character writes.
module text_screen_writer_dirty_span import tsw_pkg::*; #(
  parameter int TAB_WIDTH   = TSW_TAB_WIDTH,
  parameter int QUEUE_DEPTH = TSW_QUEUE_DEPTH
) (
  input  logic                      clk,
  input  logic                      rst_n,

  input  logic                      in_valid,
  output logic                      in_stall,
  input  logic [TSW_REQ_W-1:0]      in_req_type,
  input  logic [TSW_CODE_W-1:0]     in_char_code,
  input  logic [TSW_ATTR_W-1:0]     in_attribute,
  input  logic [TSW_POS_W-1:0]      in_col_pos,
  input  logic [TSW_POS_W-1:0]      in_row_pos,

  output logic                      out_valid,
  input  logic                      out_stall,
  output logic                      out_span_valid,
  output logic [TSW_ROW_W-1:0]      out_span_first_row,
  output logic [TSW_ROW_W-1:0]      out_span_last_row,
  output logic [TSW_COL_W-1:0]      out_span_first_col,
  output logic [TSW_COL_W-1:0]      out_span_last_col,
  output logic                      out_cursor_valid,
  output logic [TSW_COL_W-1:0]      out_cursor_col,
  output logic [TSW_ROW_W-1:0]      out_cursor_row,
  output logic                      out_read_valid,
  output logic [TSW_CHAR_W-1:0]     out_read_char,
  output logic [TSW_ATTR_W-1:0]     out_read_attr,

  input  logic                      cfg_valid,
  output logic                      cfg_ready,
  input  logic [TSW_CFG_IDX_W-1:0]  cfg_index,
  input  logic [TSW_CFG_DATA_W-1:0] cfg_data
);

  // Configuration registers
  tsw_cfg_t cfg_r, cfg_nxt;

  // Front to queue to back
  tsw_cmd_t front_cmd, head_cmd;
  logic     push, pop, q_full, q_empty, init_busy;
  tsw_res_t res;

  assign cfg_ready = 1'b1;

  // Index past the last register is accepted and dropped
  always_comb begin
    cfg_nxt = cfg_r;
    if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        CFG_SCREEN_COLS: cfg_nxt.screen_cols = cfg_data;
        CFG_SCREEN_ROWS: cfg_nxt.screen_rows = cfg_data[TSW_SROWS_W-1:0];
        CFG_CURSOR_EN:   cfg_nxt.cursor_en   = cfg_data[0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.screen_cols <= TSW_SCOLS_W'(80);
      cfg_r.screen_rows <= TSW_SROWS_W'(25);
      cfg_r.cursor_en   <= 1'b0;
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

  // Decode: drops CR and unknown types, folds special codes
  tsw_front u_front (
    .in_valid     (in_valid),
    .in_req_type  (in_req_type),
    .in_char_code (in_char_code),
    .in_attribute (in_attribute),
    .in_col_pos   (in_col_pos),
    .in_row_pos   (in_row_pos),
    .q_full       (q_full),
    .init_busy    (init_busy),
    .in_stall     (in_stall),
    .push         (push),
    .cmd          (front_cmd)
  );

  // Short command queue decouples intake from RAM work
  tsw_fifo #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk   (clk),
    .rst_n (rst_n),
    .push  (push),
    .din   (front_cmd),
    .pop   (pop),
    .dout  (head_cmd),
    .full  (q_full),
    .empty (q_empty)
  );

  // Cell RAM, cursor, dirty span and result register
  tsw_back #(
    .TAB_WIDTH (TAB_WIDTH)
  ) u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg       (cfg_r),
    .head      (head_cmd),
    .q_empty   (q_empty),
    .pop       (pop),
    .init_busy (init_busy),
    .out_stall (out_stall),
    .out_valid (out_valid),
    .res       (res)
  );

  assign out_span_valid     = res.span_valid;
  assign out_span_first_row = res.span_first_row;
  assign out_span_last_row  = res.span_last_row;
  assign out_span_first_col = res.span_first_col;
  assign out_span_last_col  = res.span_last_col;
  assign out_cursor_valid   = res.cursor_valid;
  assign out_cursor_col     = res.cursor_col;
  assign out_cursor_row     = res.cursor_row;
  assign out_read_valid     = res.read_valid;
  assign out_read_char      = res.read_char;
  assign out_read_attr      = res.read_attr;

endmodule

@@ hdl/tsw_ram.sv @@
module tsw_ram import tsw_pkg::*; #(
  parameter int WIDTH = TSW_CELL_W,
  parameter int DEPTH = TSW_CELLS
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[waddr] <= wdata;
    end
    rdata_r <= mem_r[raddr];
  end

  assign rdata = rdata_r;

endmodule

@@ hdl/tsw_fifo.sv @@
module tsw_fifo import tsw_pkg::*; #(
  parameter int DEPTH = TSW_QUEUE_DEPTH
) (
  input  logic     clk,
  input  logic     rst_n,
  input  logic     push,
  input  tsw_cmd_t din,
  input  logic     pop,
  output tsw_cmd_t dout,
  output logic     full,
  output logic     empty
);

  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);

  tsw_cmd_t           slot_r [DEPTH];
  logic [PTR_W-1:0]   wr_ptr_r, wr_ptr_nxt;
  logic [PTR_W-1:0]   rd_ptr_r, rd_ptr_nxt;
  logic [CNT_W-1:0]   count_r, count_nxt;

  function automatic logic [PTR_W-1:0] ptr_inc(input logic [PTR_W-1:0] p);
    return (p == PTR_W'(DEPTH - 1)) ? '0 : p + 1'b1;
  endfunction

  always_comb begin
    wr_ptr_nxt = push ? ptr_inc(wr_ptr_r) : wr_ptr_r;
    rd_ptr_nxt = pop ? ptr_inc(rd_ptr_r) : rd_ptr_r;
    count_nxt  = count_r;
    if (push && !pop) begin
      count_nxt = count_r + 1'b1;
    end else if (pop && !push) begin
      count_nxt = count_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      slot_r[wr_ptr_r] <= din;
    end
  end

  assign dout  = slot_r[rd_ptr_r];
  assign full  = (count_r == CNT_W'(DEPTH));
  assign empty = (count_r == '0);

endmodule

@@ hdl/tsw_front.sv @@
module tsw_front import tsw_pkg::*; (
  input  logic                  in_valid,
  input  logic [TSW_REQ_W-1:0]  in_req_type,
  input  logic [TSW_CODE_W-1:0] in_char_code,
  input  logic [TSW_ATTR_W-1:0] in_attribute,
  input  logic [TSW_POS_W-1:0]  in_col_pos,
  input  logic [TSW_POS_W-1:0]  in_row_pos,
  input  logic                  q_full,
  input  logic                  init_busy,
  output logic                  in_stall,
  output logic                  push,
  output tsw_cmd_t              cmd
);

  logic                  keep;
  logic [TSW_CHAR_W-1:0] norm_ch;

  // NUL prints as a space, anything past the BMP as the replacement code
  always_comb begin
    if (in_char_code == CODE_NUL) begin
      norm_ch = CHAR_SPACE;
    end else if (in_char_code > CODE_BMP_MAX) begin
      norm_ch = CHAR_REPL;
    end else begin
      norm_ch = in_char_code[TSW_CHAR_W-1:0];
    end
  end

  always_comb begin
    keep        = 1'b1;
    cmd.op      = OP_PUT;
    cmd.ch      = norm_ch;
    cmd.attr    = in_attribute;
    cmd.col_pos = in_col_pos;
    cmd.row_pos = in_row_pos;
    unique case (in_req_type)
      REQ_WRITE: begin
        if (in_char_code == CODE_TAB) begin
          cmd.op = OP_TAB;
          cmd.ch = CHAR_SPACE;
        end else if (in_char_code == CODE_CR) begin
          keep = 1'b0;
        end else if (in_char_code == CODE_LF) begin
          cmd.op = OP_NL;
        end
      end
      REQ_GOTO:  cmd.op = OP_GOTO;
      REQ_FLUSH: cmd.op = OP_FLUSH;
      REQ_CLEAR: cmd.op = OP_CLEAR;
      REQ_READ:  cmd.op = OP_READ;
      default:   keep = 1'b0;
    endcase
  end

  assign in_stall = q_full | init_busy;
  assign push     = in_valid & ~in_stall & keep;

endmodule

@@ hdl/tsw_back.sv @@
module tsw_back import tsw_pkg::*; #(
  parameter int TAB_WIDTH = TSW_TAB_WIDTH
) (
  input  logic     clk,
  input  logic     rst_n,
  input  tsw_cfg_t cfg,
  input  tsw_cmd_t head,
  input  logic     q_empty,
  output logic     pop,
  output logic     init_busy,
  input  logic     out_stall,
  output logic     out_valid,
  output tsw_res_t res
);

  localparam int TAB_CNT_W = (TAB_WIDTH > 1) ? $clog2(TAB_WIDTH) : 1;

  localparam logic [2:0] ST_IDLE   = 3'd0;
  localparam logic [2:0] ST_PUT    = 3'd1;
  localparam logic [2:0] ST_PUT_RD = 3'd2;
  localparam logic [2:0] ST_READ   = 3'd3;
  localparam logic [2:0] ST_SWEEP  = 3'd4;

  logic [2:0]            state_r, state_nxt;
  logic [TSW_ADDR_W-1:0] sweep_cnt_r, sweep_cnt_nxt;
  logic                  clr_emit_r, clr_emit_nxt;
  logic [TAB_CNT_W-1:0]  tab_cnt_r, tab_cnt_nxt;
  logic [TSW_CHAR_W-1:0] ch_r, ch_nxt;
  logic [TSW_ATTR_W-1:0] attr_r, attr_nxt;
  logic                  oob_r, oob_nxt;
  logic [TSW_COL_W-1:0]  cur_col_r, cur_col_nxt;
  logic [TSW_ROW_W-1:0]  cur_row_r, cur_row_nxt;
  logic                  dirty_r, dirty_nxt;
  logic [TSW_ROW_W-1:0]  dirty_row_r, dirty_row_nxt;
  logic [TSW_COL_W-1:0]  dirty_first_r, dirty_first_nxt;
  logic [TSW_COL_W-1:0]  dirty_last_r, dirty_last_nxt;
  logic                  out_valid_r, out_valid_nxt;
  tsw_res_t              res_r, res_nxt;

  logic [TSW_SCOLS_W-1:0] used_cols;
  logic [TSW_SROWS_W-1:0] used_rows;
  logic [TSW_COL_W-1:0]   last_col, sat_col, goto_col;
  logic [TSW_ROW_W-1:0]   last_row, nl_row, goto_row;
  logic [TSW_SCOLS_W-1:0] col_inc;
  logic [TSW_SROWS_W-1:0] row_inc;
  logic [TSW_ADDR_W-1:0]  cur_addr;
  logic                   slot_free, needs_slot, cell_diff;
  logic                   emit;
  tsw_res_t               emit_res;

  logic                   ram_we;
  logic [TSW_ADDR_W-1:0]  ram_waddr, ram_raddr;
  logic [TSW_CELL_W-1:0]  ram_wdata, ram_rdata;

  tsw_ram #(
    .WIDTH (TSW_CELL_W),
    .DEPTH (TSW_CELLS)
  ) u_cells (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  // Screen size as used: zero taken as one, clamped to the store
  always_comb begin
    if (cfg.screen_cols == '0) begin
      used_cols = TSW_SCOLS_W'(1);
    end else if (cfg.screen_cols > TSW_SCOLS_W'(TSW_MAX_COLS)) begin
      used_cols = TSW_SCOLS_W'(TSW_MAX_COLS);
    end else begin
      used_cols = cfg.screen_cols;
    end
    if (cfg.screen_rows == '0) begin
      used_rows = TSW_SROWS_W'(1);
    end else if (cfg.screen_rows > TSW_SROWS_W'(TSW_MAX_ROWS)) begin
      used_rows = TSW_SROWS_W'(TSW_MAX_ROWS);
    end else begin
      used_rows = cfg.screen_rows;
    end
  end

  assign last_col = TSW_COL_W'(used_cols - 1'b1);
  assign last_row = TSW_ROW_W'(used_rows - 1'b1);
  assign col_inc  = {1'b0, cur_col_r} + 1'b1;
  assign row_inc  = {1'b0, cur_row_r} + 1'b1;
  assign sat_col  = (col_inc >= used_cols) ? last_col : col_inc[TSW_COL_W-1:0];
  assign nl_row   = (row_inc >= used_rows) ? last_row : row_inc[TSW_ROW_W-1:0];
  assign cur_addr = {cur_row_r, cur_col_r};

  // Goto is one-based and clamped to the screen in use
  always_comb begin
    if (head.col_pos == '0) begin
      goto_col = '0;
    end else if (head.col_pos > used_cols) begin
      goto_col = last_col;
    end else begin
      goto_col = TSW_COL_W'(head.col_pos - 1'b1);
    end
    if (head.row_pos == '0) begin
      goto_row = '0;
    end else if (head.row_pos > {1'b0, used_rows}) begin
      goto_row = last_row;
    end else begin
      goto_row = TSW_ROW_W'(head.row_pos - 1'b1);
    end
  end

  assign slot_free  = ~out_valid_r | ~out_stall;
  assign needs_slot = (head.op != OP_PUT) && (head.op != OP_TAB);
  assign pop        = (state_r == ST_IDLE) && !q_empty && (!needs_slot || slot_free);
  assign cell_diff  = (ram_rdata != {ch_r, attr_r});

  always_comb begin
    if (state_r == ST_IDLE && head.op == OP_READ) begin
      ram_raddr = {head.row_pos[TSW_ROW_W-1:0], head.col_pos[TSW_COL_W-1:0]};
    end else begin
      ram_raddr = cur_addr;
    end
  end

  always_comb begin
    state_nxt       = state_r;
    sweep_cnt_nxt   = sweep_cnt_r;
    clr_emit_nxt    = clr_emit_r;
    tab_cnt_nxt     = tab_cnt_r;
    ch_nxt          = ch_r;
    attr_nxt        = attr_r;
    oob_nxt         = oob_r;
    cur_col_nxt     = cur_col_r;
    cur_row_nxt     = cur_row_r;
    dirty_nxt       = dirty_r;
    dirty_row_nxt   = dirty_row_r;
    dirty_first_nxt = dirty_first_r;
    dirty_last_nxt  = dirty_last_r;
    ram_we          = 1'b0;
    ram_waddr       = cur_addr;
    ram_wdata       = {ch_r, attr_r};
    emit            = 1'b0;
    emit_res        = '0;

    unique case (state_r)
      ST_IDLE: begin
        if (pop) begin
          case (head.op)
            OP_PUT, OP_TAB: begin
              ch_nxt      = head.ch;
              attr_nxt    = head.attr;
              tab_cnt_nxt = (head.op == OP_TAB) ? TAB_CNT_W'(TAB_WIDTH - 1) : '0;
              state_nxt   = ST_PUT;
            end
            OP_NL, OP_GOTO: begin
              emit = dirty_r | cfg.cursor_en;
              if (dirty_r) begin
                emit_res.span_valid     = 1'b1;
                emit_res.span_first_row = dirty_row_r;
                emit_res.span_last_row  = dirty_row_r;
                emit_res.span_first_col = dirty_first_r;
                emit_res.span_last_col  = dirty_last_r;
              end
              cur_col_nxt = (head.op == OP_NL) ? '0 : goto_col;
              cur_row_nxt = (head.op == OP_NL) ? nl_row : goto_row;
              if (cfg.cursor_en) begin
                emit_res.cursor_valid = 1'b1;
                emit_res.cursor_col   = cur_col_nxt;
                emit_res.cursor_row   = cur_row_nxt;
              end
              dirty_nxt = 1'b0;
            end
            OP_FLUSH: begin
              emit                    = dirty_r;
              emit_res.span_valid     = 1'b1;
              emit_res.span_first_row = dirty_row_r;
              emit_res.span_last_row  = dirty_row_r;
              emit_res.span_first_col = dirty_first_r;
              emit_res.span_last_col  = dirty_last_r;
              if (cfg.cursor_en) begin
                emit_res.cursor_valid = 1'b1;
                emit_res.cursor_col   = cur_col_r;
                emit_res.cursor_row   = cur_row_r;
              end
              dirty_nxt = 1'b0;
            end
            OP_CLEAR: begin
              sweep_cnt_nxt = '0;
              clr_emit_nxt  = 1'b1;
              state_nxt     = ST_SWEEP;
            end
            OP_READ: begin
              oob_nxt   = (head.col_pos >= TSW_POS_W'(TSW_MAX_COLS)) ||
                          (head.row_pos >= TSW_POS_W'(TSW_MAX_ROWS));
              state_nxt = ST_READ;
            end
            default: ;
          endcase
        end
      end
      ST_PUT: begin
        if (cell_diff) begin
          ram_we         = 1'b1;
          dirty_nxt      = 1'b1;
          dirty_row_nxt  = cur_row_r;
          dirty_last_nxt = cur_col_r;
          if (!dirty_r) begin
            dirty_first_nxt = cur_col_r;
          end
        end
        cur_col_nxt = sat_col;
        if (tab_cnt_r != '0) begin
          tab_cnt_nxt = tab_cnt_r - 1'b1;
          state_nxt   = ST_PUT_RD;
        end else begin
          state_nxt = ST_IDLE;
        end
      end
      ST_PUT_RD: begin
        state_nxt = ST_PUT;
      end
      ST_READ: begin
        emit                = 1'b1;
        emit_res.read_valid = 1'b1;
        emit_res.read_char  = oob_r ? CHAR_SPACE : ram_rdata[TSW_CELL_W-1:TSW_ATTR_W];
        emit_res.read_attr  = oob_r ? ATTR_BLANK : ram_rdata[TSW_ATTR_W-1:0];
        state_nxt           = ST_IDLE;
      end
      ST_SWEEP: begin
        ram_we        = 1'b1;
        ram_waddr     = sweep_cnt_r;
        ram_wdata     = {CHAR_SPACE, ATTR_BLANK};
        sweep_cnt_nxt = sweep_cnt_r + 1'b1;
        if (&sweep_cnt_r) begin
          emit                    = clr_emit_r;
          emit_res.span_valid     = 1'b1;
          emit_res.span_last_row  = last_row;
          emit_res.span_last_col  = last_col;
          clr_emit_nxt            = 1'b0;
          state_nxt               = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  // One-deep result register; a result only lands when the slot is free
  always_comb begin
    out_valid_nxt = out_valid_r & out_stall;
    res_nxt       = res_r;
    if (emit) begin
      out_valid_nxt = 1'b1;
      res_nxt       = emit_res;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r       <= ST_SWEEP;
      sweep_cnt_r   <= '0;
      clr_emit_r    <= 1'b0;
      tab_cnt_r     <= '0;
      cur_col_r     <= '0;
      cur_row_r     <= '0;
      dirty_r       <= 1'b0;
      dirty_row_r   <= '0;
      dirty_first_r <= '0;
      dirty_last_r  <= '0;
      out_valid_r   <= 1'b0;
    end else begin
      state_r       <= state_nxt;
      sweep_cnt_r   <= sweep_cnt_nxt;
      clr_emit_r    <= clr_emit_nxt;
      tab_cnt_r     <= tab_cnt_nxt;
      cur_col_r     <= cur_col_nxt;
      cur_row_r     <= cur_row_nxt;
      dirty_r       <= dirty_nxt;
      dirty_row_r   <= dirty_row_nxt;
      dirty_first_r <= dirty_first_nxt;
      dirty_last_r  <= dirty_last_nxt;
      out_valid_r   <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    ch_r   <= ch_nxt;
    attr_r <= attr_nxt;
    oob_r  <= oob_nxt;
    res_r  <= res_nxt;
  end

  assign init_busy = (state_r == ST_SWEEP) && !clr_emit_r;
  assign out_valid = out_valid_r;
  assign res       = res_r;

endmodule

@@ hdl/tsw_checker.sv @@
`include "text_screen_writer_dirty_span_assert.svh"

module tsw_checker import tsw_pkg::*; (
  input logic                  clk,
  input logic                  rst_n,
  input logic                  in_stall,
  input logic                  out_valid,
  input logic                  out_stall,
  input logic                  out_span_valid,
  input logic [TSW_ROW_W-1:0]  out_span_first_row,
  input logic [TSW_ROW_W-1:0]  out_span_last_row,
  input logic [TSW_COL_W-1:0]  out_span_first_col,
  input logic [TSW_COL_W-1:0]  out_span_last_col,
  input logic                  out_cursor_valid,
  input logic                  out_read_valid,
  input logic [TSW_CHAR_W-1:0] out_read_char,
  input logic [TSW_ATTR_W-1:0] out_read_attr
);

  // stalled result beat holds its valid, read-cell and span column fields
  `TSW_ASSERT_NEXT(a_out_hold, clk, rst_n, out_valid && out_stall, out_valid && $stable(out_read_char) && $stable(out_read_attr) && $stable(out_span_last_col) && $stable(out_span_first_col))

  // every result beat reports something
  `TSW_ASSERT_IMP(a_out_nonempty, clk, rst_n, out_valid, out_span_valid || out_cursor_valid || out_read_valid)

  // a read answer travels alone
  `TSW_ASSERT_IMP(a_read_alone, clk, rst_n, out_valid && out_read_valid, !out_span_valid && !out_cursor_valid)

  // only clear reports more than one row, always from the top left, no cursor
  `TSW_ASSERT_IMP(a_clear_span, clk, rst_n, out_valid && out_span_valid && (out_span_first_row != out_span_last_row), out_span_first_row == 0 && out_span_first_col == 0 && !out_cursor_valid)

  // RAM blanking pass holds off input right after reset
  `TSW_ASSERT_NEXT_ALWAYS(a_init_stall, clk, !rst_n, in_stall)

endmodule

bind text_screen_writer_dirty_span tsw_checker u_tsw_checker (.*);
